// ----- sv/wfc_pkg.sv -----
// Package for the word frequency counter: payload structs, opcodes, status codes,
// controller commands and the character classification helper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wfc_pkg;

  localparam int unsigned TableEntriesDefault = 512;
  localparam int unsigned WordCharsDefault    = 15;
  localparam int unsigned CountBitsDefault    = 16;
  localparam int unsigned MaxChars            = 15;

  localparam logic [1:0] OpChar = 2'd0;
  localparam logic [1:0] OpEnd  = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatTooLong = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic [1:0] StatBadIdx  = 2'd3;

  localparam logic [7:0] Apostrophe = 8'd39;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [8:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        word_done;
    logic [8:0]  slot;
    logic [15:0] occurrences;
    logic [63:0] chars_first;
    logic [55:0] chars_rest;
    logic [3:0]  word_length;
    logic [9:0]  distinct_words;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // capture accepted input item
    logic append_char;  // append folded char to pending word
    logic set_err;      // latch sticky error from err_code
    logic [1:0] err_code;
    logic scan_start;   // reset scan pointer, snapshot word
    logic scan_rd;      // issue memory read at scan pointer
    logic scan_step;    // compare registered read data, advance
    logic upd_hit;      // write incremented count at hit slot
    logic upd_new;      // append word at used_slots
    logic read_rd;      // issue memory read at entry_index
    logic res_idle;     // result: plain status and word count, other fields zero
    logic res_word;     // result: completed word
    logic res_read;     // result: read data
    logic [1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       is_letter;
    logic       word_full;
    logic       word_pending;
    logic [1:0] err;
    logic       hit;        // registered compare matched
    logic       scan_last;  // compared entry was the last stored one
    logic       scan_empty; // nothing stored
    logic       table_full;
    logic       idx_bad;
    logic       out_busy;   // result register still holds an item
  } stat_t;

  function automatic logic is_word_char(logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122)) ||
           (c == Apostrophe);
  endfunction

  function automatic logic [7:0] fold_char(logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) ? c + 8'd32 : c;
  endfunction

endpackage

// ----- sv/wfc_ctrl.sv -----
// Controller state machine of the word frequency counter.
// Depends on wfc_pkg; talks to wfc_datapath by cmd_t and stat_t only.
`timescale 1ns / 1ps

module wfc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wfc_pkg::stat_t stat_i,
  output wfc_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDecode = 7'b0000010,
    StScanRd = 7'b0000100,
    StScanCp = 7'b0001000,
    StReadWt = 7'b0010000,
    StReadRs = 7'b0100000,
    StEmit   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (!stat_i.out_busy) begin
          state_d = StIdle;
          if (stat_i.err != wfc_pkg::StatOk) begin
            cmd_o.res_idle = 1'b1;
            cmd_o.res_status = stat_i.err;
          end else if (stat_i.op == wfc_pkg::OpChar && stat_i.is_letter) begin
            if (stat_i.word_full) begin
              cmd_o.set_err = 1'b1;
              cmd_o.err_code = wfc_pkg::StatTooLong;
              cmd_o.res_idle = 1'b1;
              cmd_o.res_status = wfc_pkg::StatTooLong;
            end else begin
              cmd_o.append_char = 1'b1;
              cmd_o.res_idle = 1'b1;
            end
          end else if ((stat_i.op == wfc_pkg::OpChar || stat_i.op == wfc_pkg::OpEnd)
                       && stat_i.word_pending) begin
            cmd_o.scan_start = 1'b1;
            state_d = StScanRd;
          end else if (stat_i.op == wfc_pkg::OpRead) begin
            if (stat_i.idx_bad) begin
              cmd_o.res_idle = 1'b1;
              cmd_o.res_status = wfc_pkg::StatBadIdx;
            end else begin
              cmd_o.read_rd = 1'b1;
              state_d = StReadWt;
            end
          end else begin
            cmd_o.res_idle = 1'b1;
          end
        end
      end
      StScanRd: begin
        if (stat_i.scan_empty) begin
          state_d = StEmit;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = StScanCp;
        end
      end
      StScanCp: begin
        // Stop once the previous compare hit or covered the last entry.
        if (stat_i.hit || stat_i.scan_last) begin
          state_d = StEmit;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.scan_rd = 1'b1;
        end
      end
      StEmit: begin
        state_d = StIdle;
        if (stat_i.hit) begin
          cmd_o.upd_hit = 1'b1;
          cmd_o.res_word = 1'b1;
        end else if (stat_i.table_full) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err_code = wfc_pkg::StatFull;
          cmd_o.res_idle = 1'b1;
          cmd_o.res_status = wfc_pkg::StatFull;
        end else begin
          cmd_o.upd_new = 1'b1;
          cmd_o.res_word = 1'b1;
        end
      end
      StReadWt: begin
        state_d = StReadRs;
      end
      StReadRs: begin
        cmd_o.res_read = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/wfc_datapath.sv -----
// Datapath of the word frequency counter: pending word, word table memory,
// scan compare and the result register. Depends on wfc_pkg.
`timescale 1ns / 1ps

module wfc_datapath #(
  parameter int unsigned TableEntries = wfc_pkg::TableEntriesDefault,
  parameter int unsigned WordChars    = wfc_pkg::WordCharsDefault,
  parameter int unsigned CountBits    = wfc_pkg::CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfc_pkg::in_item_t   in_data_i,
  input  wfc_pkg::cmd_t       cmd_i,
  output wfc_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wfc_pkg::out_item_t  out_data_o
);

  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned UsedW = $clog2(TableEntries + 1);
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef struct packed {
    logic [63:0]          first;
    logic [55:0]          rest;
    logic [3:0]           len;
    logic [CountBits-1:0] cnt;
  } entry_t;

  wfc_pkg::in_item_t item_q;
  logic [7:0]        word_q [wfc_pkg::MaxChars];
  logic [3:0]        len_q;
  logic [1:0]        err_q;
  logic [UsedW-1:0]  used_q;
  logic [IdxW-1:0]   ptr_q;
  logic              hit_q;
  logic              last_q;
  logic [63:0]       first_q;
  logic [55:0]       rest_q;
  logic [3:0]        wlen_q;
  entry_t            mem_q [TableEntries];
  entry_t            rd_q;
  logic              out_valid_q;
  wfc_pkg::out_item_t out_q;

  logic [63:0] first_w;
  logic [55:0] rest_w;
  logic        match;
  logic [CountBits-1:0] cnt_inc;
  logic [15:0] occ_sat;

  // Pack the pending word into its two output fields, zero padded.
  always_comb begin
    first_w = '0;
    rest_w  = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len_q) first_w[8*i +: 8] = word_q[i];
    end
    for (int i = 0; i < 7; i++) begin
      if (4'(i + 8) < len_q) rest_w[8*i +: 8] = word_q[i+8];
    end
  end

  assign match = (rd_q.len == wlen_q) && (rd_q.first == first_q) && (rd_q.rest == rest_q);
  assign cnt_inc = (rd_q.cnt < CountMax) ? rd_q.cnt + 1'b1 : rd_q.cnt;

  // Status toward the controller.
  always_comb begin
    stat_o.op           = item_q.op;
    stat_o.is_letter    = wfc_pkg::is_word_char(item_q.char_code);
    stat_o.word_full    = (len_q >= 4'(WordChars));
    stat_o.word_pending = (len_q != '0);
    stat_o.err          = err_q;
    stat_o.hit          = hit_q;
    stat_o.scan_last    = last_q;
    stat_o.scan_empty   = (used_q == '0);
    stat_o.table_full   = (used_q >= UsedW'(TableEntries));
    stat_o.idx_bad      = (int'(item_q.entry_index) >= int'(used_q)) ||
                          (int'(item_q.entry_index) >= int'(TableEntries));
    stat_o.out_busy     = out_valid_q;
  end

  // Control registers: pending length, error, fill count, scan flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      err_q  <= wfc_pkg::StatOk;
      used_q <= '0;
      ptr_q  <= '0;
      hit_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.append_char) len_q <= len_q + 4'd1;
      if (cmd_i.scan_start) begin
        len_q  <= '0;
        ptr_q  <= '0;
        hit_q  <= 1'b0;
        last_q <= 1'b0;
      end
      if (cmd_i.set_err) err_q <= cmd_i.err_code;
      if (cmd_i.scan_step) begin
        hit_q  <= match;
        last_q <= (UsedW'(ptr_q) + UsedW'(1) >= used_q);
        if (!match) ptr_q <= ptr_q + IdxW'(1);
      end
      if (cmd_i.upd_new) used_q <= used_q + UsedW'(1);
    end
  end

  // Input item, pending word characters and scan snapshot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.append_char) word_q[len_q] <= wfc_pkg::fold_char(item_q.char_code);
    if (cmd_i.scan_start) begin
      first_q <= first_w;
      rest_q  <= rest_w;
      wlen_q  <= len_q;
    end
  end

  // Word table memory: one write port, one registered read port.
  // On a hit the matching entry is read again so its count stays at hand.
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_hit) begin
      mem_q[ptr_q].cnt <= cnt_inc;
    end else if (cmd_i.upd_new) begin
      mem_q[used_q[IdxW-1:0]] <= '{first: first_q, rest: rest_q, len: wlen_q,
                                   cnt: CountBits'(1)};
    end
    if (cmd_i.scan_rd) begin
      rd_q <= mem_q[(cmd_i.scan_step && !match) ? ptr_q + IdxW'(1) : ptr_q];
    end else if (cmd_i.read_rd) begin
      rd_q <= mem_q[IdxW'(item_q.entry_index)];
    end
  end

  always_comb begin
    if (cmd_i.upd_hit) occ_sat = (CountBits > 16 && cnt_inc > CountBits'(16'hFFFF))
                                 ? 16'hFFFF : 16'(cnt_inc);
    else occ_sat = (CountBits > 16 && rd_q.cnt > CountBits'(16'hFFFF))
                   ? 16'hFFFF : 16'(rd_q.cnt);
  end

  // Result register; the controller only loads it when it is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_idle || cmd_i.res_word || cmd_i.res_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_idle) begin
      out_q <= '{status: cmd_i.res_status, word_done: 1'b0, slot: 9'd0,
                 occurrences: 16'd0, chars_first: 64'd0, chars_rest: 56'd0,
                 word_length: 4'd0, distinct_words: 10'(used_q)};
    end else if (cmd_i.res_word) begin
      out_q.status      <= wfc_pkg::StatOk;
      out_q.word_done   <= 1'b1;
      out_q.slot        <= cmd_i.upd_hit ? 9'(ptr_q) : 9'(used_q);
      out_q.occurrences <= cmd_i.upd_hit ? occ_sat : 16'd1;
      out_q.chars_first <= first_q;
      out_q.chars_rest  <= rest_q;
      out_q.word_length <= wlen_q;
      out_q.distinct_words <= cmd_i.upd_new ? 10'(used_q + UsedW'(1)) : 10'(used_q);
    end else if (cmd_i.res_read) begin
      out_q.status      <= wfc_pkg::StatOk;
      out_q.word_done   <= 1'b0;
      out_q.slot        <= item_q.entry_index;
      out_q.occurrences <= occ_sat;
      out_q.chars_first <= rd_q.first;
      out_q.chars_rest  <= rd_q.rest;
      out_q.word_length <= rd_q.len;
      out_q.distinct_words <= 10'(used_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/word_frequency_counter_core.sv -----
// Word frequency counter: counts distinct lower-case words in an ASCII stream.
//
// Input channel in_valid_i/in_ready_o/in_data_i carries one item per transfer:
// a text character, an end-of-text mark, or a table read. Output channel
// out_valid_o/out_ready_i/out_data_o gives exactly one result per input item.
// A character that extends a word, a separator with no pending word or an
// ignored item is answered from the decode step; a read passes through decode,
// a memory read wait and a result step. A finished word scans the stored words
// in insertion order, one entry per cycle through the table memory's registered
// read port, stopping at a match or at the last stored word (at most the table
// size); an empty table skips the scan.
// Items are taken one at a time; a new item is accepted while the previous
// result waits in the output register, and processing holds in its decode
// step while that register is still full, so a stalled receiver stalls the
// block without losing results.
// Reset clears the pending word, the stored-word count and the sticky error;
// table contents are not cleared since only stored slots are ever read.
// After a too-long word or table-full error every item returns that status
// until reset.
// Depends on wfc_pkg, wfc_ctrl and wfc_datapath.
`timescale 1ns / 1ps

module word_frequency_counter_core #(
  parameter int unsigned TableEntries = wfc_pkg::TableEntriesDefault,
  parameter int unsigned WordChars    = wfc_pkg::WordCharsDefault,
  parameter int unsigned CountBits    = wfc_pkg::CountBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wfc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wfc_pkg::out_item_t out_data_o
);

  wfc_pkg::cmd_t  cmd;
  wfc_pkg::stat_t stat;

  wfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wfc_datapath #(
    .TableEntries (TableEntries),
    .WordChars    (WordChars),
    .CountBits    (CountBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A result is only loaded into an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.res_idle || cmd.res_word || cmd.res_read) |-> !stat.out_busy)
    else $error("result loaded over a pending result");

  // A completed word always reports a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.word_done) |-> (out_data_o.word_length != 4'd0))
    else $error("completed word with zero length");

  // Once set, the sticky error never clears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(stat.err) != wfc_pkg::StatOk) |-> (stat.err == $past(stat.err)))
    else $error("sticky error changed");

endmodule
